[hdl/spcb_pkg.sv]
// Shared types and constants of the scaled post-column blitter.
// Holds the configuration, item and result layouts and the parser phase codes.
// No dependencies.
package spcb_pkg;

  localparam int VIRTUAL_WIDTH_DEF = 320;
  localparam int ADDR_BITS_DEF     = 24;

  // Configuration register widths
  localparam int SCR_WIDTH_W = 12;
  localparam int PITCH_W     = 13;
  localparam int BASE_W      = 24;
  localparam int STEP_W      = 18;
  localparam int SCALE_W     = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Item and result field widths
  localparam int COL_X_W    = 9;
  localparam int BYTE_W     = 8;
  localparam int ROW_ADDR_W = 24;
  localparam int SPAN_W     = 4;

  // Internal widths
  localparam int ROW_W  = 12;
  localparam int FRAC_W = 16;

  localparam int MAX_SPANS = 9;
  localparam int CNT_W     = 4;

  localparam logic [BYTE_W-1:0] END_MARK = 8'hFF;
  localparam logic [SPAN_W-1:0] REP_MAX  = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH = 3'd0,
    CFG_SCREEN_PITCH = 3'd1,
    CFG_FRAME_BASE   = 3'd2,
    CFG_SRC_STEP     = 3'd3,
    CFG_ROW_SCALE    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_SPAN = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_TOP  = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_PAD1 = 6'b001000,
    PH_DATA = 6'b010000,
    PH_PAD2 = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [SCR_WIDTH_W-1:0] screen_width;
    logic [PITCH_W-1:0]     screen_pitch;
    logic [BASE_W-1:0]      frame_base;
    logic [STEP_W-1:0]      src_step;
    logic [SCALE_W-1:0]     row_scale;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    screen_width: 12'd320,
    screen_pitch: 13'd320,
    frame_base:   24'd0,
    src_step:     18'd65536,
    row_scale:    20'd65536
  };

  typedef struct packed {
    cmd_e               command;
    logic [COL_X_W-1:0] column_x;
    logic [BYTE_W-1:0]  byte_value;
  } item_t;

  typedef struct packed {
    kind_e                 kind;
    logic [ROW_ADDR_W-1:0] row_address;
    logic [BYTE_W-1:0]     pixel_value;
    logic [SPAN_W-1:0]     span_width;
    logic                  last;
  } result_t;

  // Row evaluation status handed from the row calculator to the control
  typedef struct packed {
    logic             hit;
    logic             hit_next;
    logic [ROW_W-1:0] byte_rows;
  } row_status_t;

endpackage

[hdl/spcb_chan_if.sv]
// Valid/ready channel used for the item and result streams.
// The payload type is a parameter; no other dependencies.
interface spcb_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/spcb_row_calc.sv]
// Destination row evaluation: source-row test for the current and following
// row, frame address of the current row, and scaling of a header byte. Uses spcb_pkg.
module spcb_row_calc #(
  parameter int ADDR_W = spcb_pkg::ADDR_BITS_DEF
) (
  input  spcb_pkg::cfg_t                      cfg_i,
  input  logic [spcb_pkg::BYTE_W-1:0]         byte_i,
  input  logic [spcb_pkg::ROW_W-1:0]          next_row_i,
  input  logic [spcb_pkg::ROW_W-1:0]          row_count_i,
  input  logic [spcb_pkg::BYTE_W-1:0]         data_idx_i,
  input  logic [spcb_pkg::ROW_W-1:0]          top_row_i,
  input  logic [ADDR_W-1:0]                   col_addr_i,
  output spcb_pkg::row_status_t               status_o,
  output logic [ADDR_W-1:0]                   addr_o
);
  import spcb_pkg::*;

  localparam int ProdW  = ROW_W + STEP_W;
  localparam int LineW  = ROW_W + 1;
  localparam int AProdW = LineW + PITCH_W;
  localparam int BProdW = BYTE_W + SCALE_W;

  logic [ProdW-1:0]  src_pos;
  logic [ProdW:0]    src_pos_next;
  logic [LineW-1:0]  row_after;
  logic [LineW-1:0]  line;
  logic [AProdW-1:0] line_off;
  logic [BProdW-1:0] byte_scaled;

  always_comb begin
    src_pos      = ProdW'(next_row_i) * ProdW'(cfg_i.src_step);
    src_pos_next = {1'b0, src_pos} + (ProdW + 1)'(cfg_i.src_step);
    row_after    = {1'b0, next_row_i} + LineW'(1);

    status_o.hit = (next_row_i < row_count_i) &&
                   (src_pos[ProdW-1:FRAC_W] <= (ProdW - FRAC_W)'(data_idx_i));
    status_o.hit_next = (row_after < {1'b0, row_count_i}) &&
                        (src_pos_next[ProdW:FRAC_W] <= (ProdW - FRAC_W + 1)'(data_idx_i));

    line     = {1'b0, top_row_i} + {1'b0, next_row_i};
    line_off = AProdW'(line) * AProdW'(cfg_i.screen_pitch);
    addr_o   = col_addr_i + line_off[ADDR_W-1:0];

    byte_scaled        = BProdW'(byte_i) * BProdW'(cfg_i.row_scale);
    status_o.byte_rows = byte_scaled[FRAC_W +: ROW_W];
  end

endmodule

[hdl/spcb_col_setup.sv]
// Column setup: replication width and column base address from the virtual
// column, over two register stages (product, reciprocal quotient). Uses spcb_pkg.
module spcb_col_setup #(
  parameter int VIRTUAL_WIDTH = spcb_pkg::VIRTUAL_WIDTH_DEF,
  parameter int ADDR_W        = spcb_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [spcb_pkg::COL_X_W-1:0] column_x_i,
  input  spcb_pkg::cfg_t               cfg_i,
  output logic                         done_o,
  output logic [spcb_pkg::SPAN_W-1:0]  rep_o,
  output logic [ADDR_W-1:0]            addr_o
);
  import spcb_pkg::*;

  // Exact floor division by the virtual width: with this shift the
  // reciprocal error stays below one unit for every product in range.
  localparam int MulW   = SCR_WIDTH_W + COL_X_W + 1;
  localparam int Shift  = MulW + $clog2(VIRTUAL_WIDTH);
  localparam int RecipW = MulW + 2;
  localparam longint unsigned RecipVal =
      ((64'd1 << Shift) + 64'(VIRTUAL_WIDTH) - 64'd1) / 64'(VIRTUAL_WIDTH);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipVal);
  localparam int QuotW  = 2 * MulW + 2 - Shift;
  localparam int FullW  = MulW + RecipW;

  logic             a_valid_q;
  logic [MulW-1:0]  p_lo_q, p_hi_q;
  logic [MulW-1:0]  p_lo_d, p_hi_d;
  logic             b_valid_q;
  logic [QuotW-1:0] q_lo_q, q_hi_q;
  logic [FullW-1:0] full_lo, full_hi;
  logic [QuotW-1:0] diff;
  logic [BASE_W-1:0] base_sum;

  always_comb begin
    p_lo_d = MulW'(cfg_i.screen_width) * MulW'(column_x_i);
    p_hi_d = p_lo_d + MulW'(cfg_i.screen_width);
    full_lo = FullW'(p_lo_q) * FullW'(Recip);
    full_hi = FullW'(p_hi_q) * FullW'(Recip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_lo_q <= p_lo_d;
      p_hi_q <= p_hi_d;
    end
    if (a_valid_q) begin
      q_lo_q <= full_lo[Shift +: QuotW];
      q_hi_q <= full_hi[Shift +: QuotW];
    end
  end

  always_comb begin
    diff     = q_hi_q - q_lo_q;
    rep_o    = (diff > QuotW'(REP_MAX)) ? REP_MAX : diff[SPAN_W-1:0];
    base_sum = cfg_i.frame_base + BASE_W'(q_lo_q);
    addr_o   = base_sum[ADDR_W-1:0];
    done_o   = b_valid_q;
  end

endmodule

[hdl/scaled_post_column_blitter_unit.sv]
// Scaled post-column blitter, top level.
// Instantiates spcb_col_setup and spcb_row_calc; uses spcb_pkg and spcb_chan_if.
//
// Usage:
//   item_i carries commands: a start transaction selects the virtual column,
//   byte transactions feed the column stream of posts (top offset, length,
//   pad, pixels, pad, 0xff terminator). result_o carries row spans and the
//   terminator mark; last flags the final result of each byte transaction.
//   The cfg_* port writes one register per enabled cycle; write only while
//   no transaction is in flight.
// Structure:
//   One item register feeds the row logic and one result register drives
//   result_o. A byte transaction produces at most 9 spans: the row unit
//   evaluates one destination row per cycle while the result register can
//   take a result. A start transaction runs through the two-stage column
//   setup multiplier pipeline. Results reach result_o through the result register.
// Reset clears the configuration to its defaults and the parser to waiting
//   for a top offset with zero replication (no output until a start).
// A stalled result_o holds the result register; the next item is still taken
//   into the item register and waits there until it can produce its result.
module scaled_post_column_blitter_unit #(
  parameter int VIRTUAL_WIDTH = spcb_pkg::VIRTUAL_WIDTH_DEF,
  parameter int ADDR_BITS     = spcb_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spcb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spcb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  spcb_chan_if.sink                       item_i,
  spcb_chan_if.source                     result_o
);
  import spcb_pkg::*;

  localparam int AddrW = (ADDR_BITS < ROW_ADDR_W) ? ADDR_BITS : ROW_ADDR_W;

  cfg_t  cfg_q;
  item_t item_q;
  logic  item_valid_q;

  phase_e             phase_q, phase_d;
  logic [AddrW-1:0]   col_addr_q, col_addr_d;
  logic [SPAN_W-1:0]  rep_q, rep_d;
  logic [ROW_W-1:0]   top_row_q, top_row_d;
  logic [BYTE_W-1:0]  post_len_q, post_len_d;
  logic [BYTE_W-1:0]  data_idx_q, data_idx_d;
  logic [ROW_W-1:0]   next_row_q, next_row_d;
  logic [ROW_W-1:0]   row_count_q, row_count_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic               setup_busy_q;

  result_t res_q, emit_res;
  logic    res_valid_q;

  logic              out_free, emit, item_done, advance, setup_kick, more;
  logic [BYTE_W-1:0] idx_inc;

  logic              setup_done;
  logic [SPAN_W-1:0] setup_rep;
  logic [AddrW-1:0]  setup_addr;
  row_status_t       row_st;
  logic [AddrW-1:0]  span_addr;

  spcb_col_setup #(
    .VIRTUAL_WIDTH(VIRTUAL_WIDTH),
    .ADDR_W       (AddrW)
  ) u_col_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (setup_kick),
    .column_x_i(item_q.column_x),
    .cfg_i     (cfg_q),
    .done_o    (setup_done),
    .rep_o     (setup_rep),
    .addr_o    (setup_addr)
  );

  spcb_row_calc #(
    .ADDR_W(AddrW)
  ) u_row_calc (
    .cfg_i      (cfg_q),
    .byte_i     (item_q.byte_value),
    .next_row_i (next_row_q),
    .row_count_i(row_count_q),
    .data_idx_i (data_idx_q),
    .top_row_i  (top_row_q),
    .col_addr_i (col_addr_q),
    .status_o   (row_st),
    .addr_o     (span_addr)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data_i[SCR_WIDTH_W-1:0];
        CFG_SCREEN_PITCH: cfg_q.screen_pitch <= cfg_data_i[PITCH_W-1:0];
        CFG_FRAME_BASE:   cfg_q.frame_base   <= cfg_data_i[BASE_W-1:0];
        CFG_SRC_STEP:     cfg_q.src_step     <= cfg_data_i[STEP_W-1:0];
        CFG_ROW_SCALE:    cfg_q.row_scale    <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !res_valid_q || result_o.ready;
  assign idx_inc  = data_idx_q + BYTE_W'(1);
  assign more     = row_st.hit_next && (n_q < CNT_W'(MAX_SPANS - 1));

  always_comb begin
    phase_d     = phase_q;
    col_addr_d  = col_addr_q;
    rep_d       = rep_q;
    top_row_d   = top_row_q;
    post_len_d  = post_len_q;
    data_idx_d  = data_idx_q;
    next_row_d  = next_row_q;
    row_count_d = row_count_q;
    n_d         = n_q;
    emit        = 1'b0;
    emit_res    = '0;
    item_done   = 1'b0;
    setup_kick  = 1'b0;

    if (item_valid_q) begin
      if (item_q.command == CMD_START) begin
        setup_kick = !setup_busy_q;
        if (setup_done) begin
          item_done   = 1'b1;
          rep_d       = setup_rep;
          col_addr_d  = setup_addr;
          phase_d     = PH_TOP;
          top_row_d   = '0;
          post_len_d  = '0;
          data_idx_d  = '0;
          next_row_d  = '0;
          row_count_d = '0;
          n_d         = '0;
        end
      end else begin
        unique case (phase_q)
          PH_TOP: begin
            item_done = 1'b1;
            if (item_q.byte_value == END_MARK) begin
              phase_d = PH_IDLE;
              if (rep_q != '0) begin
                emit          = 1'b1;
                emit_res.kind = KIND_END;
                emit_res.last = 1'b1;
              end
            end else begin
              top_row_d = row_st.byte_rows;
              phase_d   = PH_LEN;
            end
          end
          PH_LEN: begin
            item_done   = 1'b1;
            post_len_d  = item_q.byte_value;
            row_count_d = row_st.byte_rows;
            next_row_d  = '0;
            data_idx_d  = '0;
            phase_d     = PH_PAD1;
          end
          PH_PAD1: begin
            item_done = 1'b1;
            phase_d   = (post_len_q == '0) ? PH_PAD2 : PH_DATA;
          end
          PH_DATA: begin
            // Without replication no span can come out of this column: skip rows
            if (rep_q != '0 && row_st.hit) begin
              emit                 = 1'b1;
              emit_res.kind        = KIND_SPAN;
              emit_res.row_address = ROW_ADDR_W'(span_addr);
              emit_res.pixel_value = item_q.byte_value;
              emit_res.span_width  = rep_q;
              emit_res.last        = !more;
              next_row_d           = next_row_q + ROW_W'(1);
              n_d                  = n_q + CNT_W'(1);
              item_done            = !more;
            end else begin
              item_done = 1'b1;
            end
            if (item_done) begin
              n_d        = '0;
              data_idx_d = idx_inc;
              if (idx_inc >= post_len_q) begin
                phase_d = PH_PAD2;
              end
            end
          end
          PH_PAD2: begin
            item_done = 1'b1;
            phase_d   = PH_TOP;
          end
          PH_IDLE: item_done = 1'b1;
          default: item_done = 1'b1;
        endcase
      end
    end
  end

  // Hold everything while a result is due but the result register is full
  assign advance = item_valid_q && (!emit || out_free);

  assign item_i.ready     = !item_valid_q || (advance && item_done);
  assign result_o.valid   = res_valid_q;
  assign result_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (item_i.valid && item_i.ready) begin
      item_valid_q <= 1'b1;
    end else if (advance && item_done) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q <= item_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_busy_q <= 1'b0;
    end else if (setup_kick) begin
      setup_busy_q <= 1'b1;
    end else if (setup_done) begin
      setup_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TOP;
      col_addr_q  <= '0;
      rep_q       <= '0;
      top_row_q   <= '0;
      post_len_q  <= '0;
      data_idx_q  <= '0;
      next_row_q  <= '0;
      row_count_q <= '0;
      n_q         <= '0;
    end else if (advance) begin
      phase_q     <= phase_d;
      col_addr_q  <= col_addr_d;
      rep_q       <= rep_d;
      top_row_q   <= top_row_d;
      post_len_q  <= post_len_d;
      data_idx_q  <= data_idx_d;
      next_row_q  <= next_row_d;
      row_count_q <= row_count_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance && emit) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= emit_res;
    end
  end

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_row_q <= row_count_q)
    else $error("next row ran past the post row count");

  a_emit_needs_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> rep_q != '0)
    else $error("result produced with zero replication");

  a_span_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q < CNT_W'(MAX_SPANS))
    else $error("span count per transaction exceeded the cap");

  a_setup_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    setup_done |-> setup_busy_q && !setup_kick)
    else $error("column setup finished without a pending start");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.kind == KIND_END |-> res_q.last)
    else $error("terminator result without last flag");

endmodule
